FILE: design/pid_position_controller_defines.svh
// Assertion macros for the PID position controller.
// Included by the top level; no other dependencies.
`ifndef PID_POSITION_CONTROLLER_DEFINES_SVH
`define PID_POSITION_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PIDPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidpc: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PIDPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidpc: next-cycle check failed");

`endif

FILE: design/pidpc_pkg.sv
// Shared types, constants and helpers of the PID position controller.
// No dependencies.
package pidpc_pkg;

    localparam int POSITION_BITS      = 16;
    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam int GAIN_W             = 16;
    localparam int LIMIT_W            = 15;
    localparam int ERR_W              = POSITION_BITS + 1;
    localparam int DIFF_W             = ERR_W + 1;
    localparam int TERM_W             = 32;
    localparam int MUL_A_W            = TERM_W;
    localparam int MUL_B_W            = GAIN_W + 1;
    localparam int PROD_W             = MUL_A_W + MUL_B_W;
    localparam int SAT_IN_W           = PROD_W + 1;
    localparam int SUM_W              = TERM_W + 3;
    localparam int DT_FRAC_BITS       = 16;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 16;
    localparam int STEP_W             = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP    = 3'd0,
        REG_KI    = 3'd1,
        REG_KD    = 3'd2,
        REG_DT    = 3'd3,
        REG_INV   = 3'd4,
        REG_TGT   = 3'd5,
        REG_LIMIT = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CLIP_NONE = 2'd0,
        CLIP_HIGH = 2'd1,
        CLIP_LOW  = 2'd2
    } clip_t;

    typedef enum logic [3:0] {
        OP_NOP    = 4'd0,
        OP_LOAD   = 4'd1,
        OP_ERR    = 4'd2,
        OP_DIFF   = 4'd3,
        OP_ADD_P  = 4'd4,
        OP_ACC    = 4'd5,
        OP_INTEG  = 4'd6,
        OP_DBASE  = 4'd7,
        OP_ADD_D  = 4'd8,
        OP_EMIT   = 4'd9
    } dp_op_t;

    typedef enum logic [1:0] {
        MA_ERR   = 2'd0,
        MA_ACC   = 2'd1,
        MA_DIFF  = 2'd2,
        MA_DBASE = 2'd3
    } mul_a_t;

    typedef enum logic [2:0] {
        MB_KP  = 3'd0,
        MB_DT  = 3'd1,
        MB_KI  = 3'd2,
        MB_KD  = 3'd3,
        MB_INV = 3'd4
    } mul_b_t;

    typedef enum logic [1:0] {
        JC_NEXT     = 2'd0,
        JC_HOLD_IN  = 2'd1,
        JC_HOLD_OUT = 2'd2
    } jump_t;

    typedef struct packed {
        dp_op_t op;
        logic   mul_en;
        mul_a_t a_sel;
        mul_b_t b_sel;
        jump_t  jc;
        logic   restart;
    } ctrl_word_t;

    typedef struct packed {
        ctrl_word_t word;
        logic       fire;
    } seq_ctl_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0]        kp;
        logic signed [GAIN_W-1:0]        ki;
        logic signed [GAIN_W-1:0]        kd;
        logic        [CFG_DATA_W-1:0]    dt;
        logic        [CFG_DATA_W-1:0]    inv_dt;
        logic signed [POSITION_BITS-1:0] target;
        logic        [LIMIT_W-1:0]       limit;
    } cfg_regs_t;

    function automatic logic signed [TERM_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
        logic [SAT_IN_W-TERM_W:0] top;
        top = v[SAT_IN_W-1:TERM_W-1];
        if ((&top) || !(|top)) begin
            return v[TERM_W-1:0];
        end
        if (v[SAT_IN_W-1]) begin
            return {1'b1, {(TERM_W-1){1'b0}}};
        end
        return {1'b0, {(TERM_W-1){1'b1}}};
    endfunction

endpackage

FILE: design/pidpc_if.sv
// Handshake channels of the PID position controller: sensor words, result
// words and configuration writes. Depends on pidpc_pkg.
interface pidpc_sensor_if import pidpc_pkg::*; ();
    logic                            valid;
    logic                            ready;
    logic signed [POSITION_BITS-1:0] joint_pos;

    modport source (output valid, output joint_pos, input ready);
    modport sink (input valid, input joint_pos, output ready);
endinterface

interface pidpc_result_if import pidpc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] command_position;
    logic [1:0]         clip_status;

    modport source (output valid, output command_position, output clip_status, input ready);
    modport sink (input valid, input command_position, input clip_status, output ready);
endinterface

interface pidpc_cfg_if import pidpc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/pidpc_regs.sv
// Configuration register file of the PID position controller.
// Depends on pidpc_pkg and pidpc_cfg_if.
module pidpc_regs
    import pidpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    pidpc_cfg_if.sink        cfg,
    output cfg_regs_t        regs
);

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_KP:    regs_next.kp     = cfg.data;
                REG_KI:    regs_next.ki     = cfg.data;
                REG_KD:    regs_next.kd     = cfg.data;
                REG_DT:    regs_next.dt     = cfg.data;
                REG_INV:   regs_next.inv_dt = cfg.data;
                REG_TGT:   regs_next.target = cfg.data;
                REG_LIMIT: regs_next.limit  = cfg.data[LIMIT_W-1:0];
                default:   regs_next        = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.kp     <= 16'sd256;
            regs_reg.ki     <= '0;
            regs_reg.kd     <= '0;
            regs_reg.dt     <= 16'd63;
            regs_reg.inv_dt <= 16'd1042;
            regs_reg.target <= 16'sd6434;
            regs_reg.limit  <= 15'd12868;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

FILE: design/pidpc_seq.sv
// Microcode sequencer: step counter, control ROM and hold logic.
// Depends on pidpc_pkg.
module pidpc_seq
    import pidpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     out_busy,
    output logic     in_ready,
    output seq_ctl_t ctl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ctrl_word_t        word;
    logic              hold;

    function automatic ctrl_word_t cw(dp_op_t op, logic mul_en, mul_a_t a_sel,
                                      mul_b_t b_sel, jump_t jc, logic restart);
        ctrl_word_t w;
        w.op      = op;
        w.mul_en  = mul_en;
        w.a_sel   = a_sel;
        w.b_sel   = b_sel;
        w.jc      = jc;
        w.restart = restart;
        return w;
    endfunction

    function automatic ctrl_word_t ucode(logic [STEP_W-1:0] step);
        ctrl_word_t w;
        unique case (step)
            4'd0:    w = cw(OP_LOAD,  1'b0, MA_ERR,   MB_KP,  JC_HOLD_IN,  1'b0);
            4'd1:    w = cw(OP_ERR,   1'b0, MA_ERR,   MB_KP,  JC_NEXT,     1'b0);
            4'd2:    w = cw(OP_DIFF,  1'b1, MA_ERR,   MB_KP,  JC_NEXT,     1'b0);
            4'd3:    w = cw(OP_ADD_P, 1'b1, MA_ERR,   MB_DT,  JC_NEXT,     1'b0);
            4'd4:    w = cw(OP_ACC,   1'b0, MA_ERR,   MB_KP,  JC_NEXT,     1'b0);
            4'd5:    w = cw(OP_NOP,   1'b1, MA_ACC,   MB_KI,  JC_NEXT,     1'b0);
            4'd6:    w = cw(OP_INTEG, 1'b1, MA_DIFF,  MB_KD,  JC_NEXT,     1'b0);
            4'd7:    w = cw(OP_DBASE, 1'b0, MA_ERR,   MB_KP,  JC_NEXT,     1'b0);
            4'd8:    w = cw(OP_NOP,   1'b1, MA_DBASE, MB_INV, JC_NEXT,     1'b0);
            4'd9:    w = cw(OP_ADD_D, 1'b0, MA_ERR,   MB_KP,  JC_NEXT,     1'b0);
            4'd10:   w = cw(OP_EMIT,  1'b0, MA_ERR,   MB_KP,  JC_HOLD_OUT, 1'b1);
            default: w = cw(OP_NOP,   1'b0, MA_ERR,   MB_KP,  JC_NEXT,     1'b1);
        endcase
        return w;
    endfunction

    assign word = ucode(step_reg);

    always_comb
    begin
        unique case (word.jc)
            JC_HOLD_IN:  hold = !in_valid;
            JC_HOLD_OUT: hold = out_busy;
            default:     hold = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hold)
        begin
            step_next = step_reg;
        end
        else if (word.restart)
        begin
            step_next = '0;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    assign in_ready  = (word.jc == JC_HOLD_IN);
    assign ctl.word  = word;
    assign ctl.fire  = !hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

FILE: design/pidpc_dp.sv
// Datapath: shared multiplier, term registers, accumulator, clamp and
// output register. Driven by the sequencer; depends on pidpc_pkg.
module pidpc_dp
    import pidpc_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  seq_ctl_t                        ctl,
    input  cfg_regs_t                       regs,
    input  logic signed [POSITION_BITS-1:0] joint_pos,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic                            out_busy,
    output logic [LIMIT_W-1:0]              command_position,
    output logic [1:0]                      clip_status
);

    logic signed [POSITION_BITS-1:0] pos_reg;
    logic signed [ERR_W-1:0]         err_reg;
    logic signed [ERR_W-1:0]         prev_err_reg;
    logic signed [DIFF_W-1:0]        diff_reg;
    logic signed [PROD_W-1:0]        prod_reg;
    logic signed [TERM_W-1:0]        acc_reg;
    logic signed [TERM_W-1:0]        integ_reg;
    logic signed [TERM_W-1:0]        dbase_reg;
    logic signed [SUM_W-1:0]         sum_reg;
    logic [LIMIT_W-1:0]              cmd_reg;
    clip_t                           clip_reg;
    logic                            out_valid_reg;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_a_ext;
    logic signed [PROD_W-1:0]   mul_b_ext;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [TERM_W-1:0]   gain_term;
    logic signed [TERM_W-1:0]   acc_next;
    logic signed [TERM_W-1:0]   prod_sat;
    logic signed [SUM_W-1:0]    limit_ext;
    logic [LIMIT_W-1:0]         cmd_next;
    clip_t                      clip_next;
    logic                       go;

    assign go = ctl.fire;

    always_comb
    begin
        unique case (ctl.word.a_sel)
            MA_ERR:   mul_a = MUL_A_W'(err_reg);
            MA_ACC:   mul_a = acc_reg;
            MA_DIFF:  mul_a = MUL_A_W'(diff_reg);
            MA_DBASE: mul_a = dbase_reg;
            default:  mul_a = '0;
        endcase
    end

    always_comb
    begin
        unique case (ctl.word.b_sel)
            MB_KP:   mul_b = MUL_B_W'(regs.kp);
            MB_DT:   mul_b = $signed({1'b0, regs.dt});
            MB_KI:   mul_b = MUL_B_W'(regs.ki);
            MB_KD:   mul_b = MUL_B_W'(regs.kd);
            MB_INV:  mul_b = $signed({1'b0, regs.inv_dt});
            default: mul_b = '0;
        endcase
    end

    assign mul_a_ext = PROD_W'(mul_a);
    assign mul_b_ext = PROD_W'(mul_b);
    assign prod_next = mul_a_ext * mul_b_ext;

    assign gain_term = sat32(SAT_IN_W'(prod_reg >>> GAIN_FRAC_BITS));
    assign prod_sat  = sat32(SAT_IN_W'(prod_reg));
    assign acc_next  = sat32(SAT_IN_W'(integ_reg) + SAT_IN_W'(prod_reg >>> DT_FRAC_BITS));
    assign limit_ext = $signed({{(SUM_W-LIMIT_W){1'b0}}, regs.limit});

    always_comb
    begin
        if (sum_reg > limit_ext)
        begin
            cmd_next  = regs.limit;
            clip_next = CLIP_HIGH;
        end
        else if (sum_reg < 0)
        begin
            cmd_next  = '0;
            clip_next = CLIP_LOW;
        end
        else
        begin
            cmd_next  = sum_reg[LIMIT_W-1:0];
            clip_next = CLIP_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && ctl.word.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (go)
        begin
            unique case (ctl.word.op)
                OP_LOAD:
                begin
                    pos_reg <= joint_pos;
                end
                OP_ERR:
                begin
                    err_reg <= ERR_W'(regs.target) - ERR_W'(pos_reg);
                    sum_reg <= SUM_W'(pos_reg);
                end
                OP_DIFF:
                begin
                    diff_reg <= DIFF_W'(err_reg) - DIFF_W'(prev_err_reg);
                end
                OP_ADD_P:
                begin
                    sum_reg <= sum_reg + SUM_W'(gain_term);
                end
                OP_ACC:
                begin
                    acc_reg <= acc_next;
                end
                OP_DBASE:
                begin
                    dbase_reg <= gain_term;
                    sum_reg   <= sum_reg + SUM_W'(integ_reg);
                end
                OP_ADD_D:
                begin
                    sum_reg <= sum_reg + SUM_W'(prod_sat);
                end
                OP_EMIT:
                begin
                    cmd_reg  <= cmd_next;
                    clip_reg <= clip_next;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg  <= '0;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (go && ctl.word.op == OP_DIFF)
            begin
                prev_err_reg <= err_reg;
            end
            if (go && ctl.word.op == OP_INTEG)
            begin
                integ_reg <= gain_term;
            end
            if (go && ctl.word.op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_busy         = out_valid_reg && !out_ready;
    assign command_position = cmd_reg;
    assign clip_status      = clip_reg;

endmodule

FILE: design/pid_position_controller.sv
// Top level of the PID position controller: register file, microcode
// sequencer and datapath. Depends on pidpc_pkg, pidpc_if and the defines header.
//
// Usage:
//   cfg    - register writes (index, data); always ready, index 7 is ignored.
//            Write only while no sample is in flight.
//   sensor - one measured position per word (signed Q4.12).
//   result - one word per sample: clamped command and clip status.
// Each sample runs 11 microcode steps through one shared 32x17 multiplier:
// the result word becomes valid after the last step, and a new sensor word
// is taken only once the sequencer is back at its first step.
// The result sits in an output register, so the next sample is taken and
// worked on while the previous result waits; if the receiver stalls, the
// sequencer holds on its last step until the register frees.
// Reset clears the error history, the integral term, the step counter and
// the output valid, and loads the register defaults (kp 1.0, ki 0, kd 0,
// dt 63, inverse dt 1042, target 6434, upper limit 12868).
`include "pid_position_controller_defines.svh"

module pid_position_controller
    import pidpc_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    pidpc_cfg_if.sink      cfg,
    pidpc_sensor_if.sink   sensor,
    pidpc_result_if.source result
);

    cfg_regs_t regs;
    seq_ctl_t  ctl;
    logic      out_busy;
    logic      in_ready;

    pidpc_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    pidpc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sensor.valid),
        .out_busy (out_busy),
        .in_ready (in_ready),
        .ctl      (ctl)
    );

    pidpc_dp #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .regs             (regs),
        .joint_pos        (sensor.joint_pos),
        .out_ready        (result.ready),
        .out_valid        (result.valid),
        .out_busy         (out_busy),
        .command_position (result.command_position),
        .clip_status      (result.clip_status)
    );

    assign sensor.ready = in_ready;

    `PIDPC_ASSERT_IMPLY(a_cmd_in_range, clk, rst_n, result.valid,
        result.command_position <= regs.limit)
    `PIDPC_ASSERT_IMPLY(a_clip_high_at_limit, clk, rst_n,
        result.valid && result.clip_status == CLIP_HIGH,
        result.command_position == regs.limit)
    `PIDPC_ASSERT_NEXT(a_one_sample_at_a_time, clk, rst_n,
        sensor.valid && sensor.ready, !sensor.ready)

endmodule

FILE: test/pid_position_controller_checker.sv
`timescale 1ns / 100ps
// Watches the config, sensor and result channels of pid_position_controller,
// predicts each command word from its own copy of the registers and the PID
// state, and counts mismatches. Depends on pidpc_pkg and pidpc_if.
module pid_position_controller_checker
    import pidpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    pidpc_cfg_if    cfg,
    pidpc_sensor_if sensor,
    pidpc_result_if result,
    output int      failures,
    output int      pending,
    output int      checked
);

    typedef struct packed {
        logic [LIMIT_W-1:0] command;
        clip_t              clip;
    } command_word_t;

    localparam longint TERM_MAX = 64'sd2147483647;
    localparam longint TERM_MIN = -64'sd2147483648;

    logic signed [GAIN_W-1:0]        kp;
    logic signed [GAIN_W-1:0]        ki;
    logic signed [GAIN_W-1:0]        kd;
    logic        [CFG_DATA_W-1:0]    dt;
    logic        [CFG_DATA_W-1:0]    inv_dt;
    logic signed [POSITION_BITS-1:0] target;
    logic        [LIMIT_W-1:0]       limit;

    longint        last_error;
    longint        integral;
    command_word_t expected_commands [$];

    function automatic longint clamp_term(input longint v);
        if (v > TERM_MAX)
        begin
            return TERM_MAX;
        end
        if (v < TERM_MIN)
        begin
            return TERM_MIN;
        end
        return v;
    endfunction

    task automatic predict_command(input logic signed [POSITION_BITS-1:0] pos,
                                   output command_word_t word);
        longint err;
        longint p_term;
        longint acc;
        longint d_base;
        longint d_term;
        longint total;
        err    = longint'(target) - longint'(pos);
        p_term = clamp_term((longint'(kp) * err) >>> GAIN_FRAC_BITS_DEF);
        acc    = clamp_term(integral + ((err * longint'(dt)) >>> DT_FRAC_BITS));
        integral = clamp_term((longint'(ki) * acc) >>> GAIN_FRAC_BITS_DEF);
        d_base = clamp_term((longint'(kd) * (err - last_error)) >>> GAIN_FRAC_BITS_DEF);
        d_term = clamp_term(d_base * longint'(inv_dt));
        last_error = err;
        total = longint'(pos) + p_term + integral + d_term;
        if (total > longint'(limit))
        begin
            word.command = limit;
            word.clip    = CLIP_HIGH;
        end
        else if (total < 0)
        begin
            word.command = '0;
            word.clip    = CLIP_LOW;
        end
        else
        begin
            word.command = total[LIMIT_W-1:0];
            word.clip    = CLIP_NONE;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        command_word_t want;
        if (!rst_n)
        begin
            kp         = 16'sd256;
            ki         = '0;
            kd         = '0;
            dt         = 16'd63;
            inv_dt     = 16'd1042;
            target     = 16'sd6434;
            limit      = 15'd12868;
            last_error = 0;
            integral   = 0;
            failures   = 0;
            checked    = 0;
            expected_commands.delete();
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_commands.size() == 0)
                begin
                    $error("result word with no sample pending: command %0d, clip %0d",
                           result.command_position, result.clip_status);
                    failures++;
                end
                else
                begin
                    want = expected_commands.pop_front();
                    checked++;
                    if (result.command_position !== want.command)
                    begin
                        $error("command_position: expected %0d, got %0d",
                               want.command, result.command_position);
                        failures++;
                    end
                    if (result.clip_status !== want.clip)
                    begin
                        $error("clip_status: expected %0d, got %0d",
                               want.clip, result.clip_status);
                        failures++;
                    end
                end
            end
            if (sensor.valid && sensor.ready)
            begin
                predict_command(sensor.joint_pos, want);
                expected_commands.push_back(want);
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_KP:    kp = cfg.data;
                    REG_KI:    ki = cfg.data;
                    REG_KD:    kd = cfg.data;
                    REG_DT:    dt = cfg.data;
                    REG_INV:   inv_dt = cfg.data;
                    REG_TGT:   target = cfg.data;
                    REG_LIMIT: limit = cfg.data[LIMIT_W-1:0];
                    default:   ;
                endcase
            end
        end
        pending = expected_commands.size();
    end

endmodule

FILE: test/pid_position_controller_tb.sv
`timescale 1ns / 100ps
// Top of the pid_position_controller testbench: clock, reset, register writes,
// sensor stimulus and verdict. Depends on pidpc_pkg, pidpc_if and the checker.
module pid_position_controller_tb;
    import pidpc_pkg::*;

    typedef enum int {
        SET_MODERATE,
        SET_FULL,
        SET_TOP,
        SET_BOTTOM
    } setting_kind_t;

    localparam logic [CFG_IDX_W-1:0] SPARE_REG_INDEX = 3'd7;
    localparam int ROUNDS            = 8;
    localparam int SAMPLES_PER_ROUND = 128;
    localparam int SETTLE_CYCLES     = 24;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int settings_count     = 0;
    int failures;
    int pending;
    int checked;
    int walk;
    int round;
    int n;

    logic [CFG_DATA_W-1:0] settings [7];

    pidpc_cfg_if    cfg_ch ();
    pidpc_sensor_if sensor_ch ();
    pidpc_result_if result_ch ();

    pid_position_controller uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .sensor (sensor_ch),
        .result (result_ch)
    );

    pid_position_controller_checker command_monitor (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_ch),
        .sensor   (sensor_ch),
        .result   (result_ch),
        .failures (failures),
        .pending  (pending),
        .checked  (checked)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        result_ch.ready <= (int'($urandom_range(99, 0)) >= receiver_stall_pct);
    end

    // ready only moves at the rising edge, so check it at the falling edge
    task automatic send_sample(input logic signed [POSITION_BITS-1:0] pos);
        while (int'($urandom_range(99, 0)) < sender_idle_pct)
        begin
            sensor_ch.valid = 1'b0;
            @(negedge clk);
        end
        sensor_ch.valid     = 1'b1;
        sensor_ch.joint_pos = pos;
        while (!sensor_ch.ready)
        begin
            @(negedge clk);
        end
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic load_settings();
        for (int i = 0; i < 7; i++)
        begin
            write_reg(CFG_IDX_W'(i), settings[i]);
        end
        cfg_ch.valid = 1'b0;
        settings_count++;
    endtask

    // hold until every sample in flight has produced its word
    task automatic drain();
        sensor_ch.valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic pick_settings(input setting_kind_t kind);
        case (kind)
            SET_TOP:
            begin
                settings[REG_KP]    = 16'h7fff;
                settings[REG_KI]    = 16'h7fff;
                settings[REG_KD]    = 16'h7fff;
                settings[REG_DT]    = 16'hffff;
                settings[REG_INV]   = 16'hffff;
                settings[REG_TGT]   = 16'h7fff;
                settings[REG_LIMIT] = 16'h7fff;
            end
            SET_BOTTOM:
            begin
                settings[REG_KP]    = 16'h8000;
                settings[REG_KI]    = 16'h8000;
                settings[REG_KD]    = 16'h8000;
                settings[REG_DT]    = 16'h0000;
                settings[REG_INV]   = 16'h0000;
                settings[REG_TGT]   = 16'h8000;
                settings[REG_LIMIT] = 16'h0000;
            end
            SET_FULL:
            begin
                for (int i = 0; i < 7; i++)
                begin
                    settings[i] = 16'($urandom());
                end
            end
            default:
            begin
                settings[REG_KP]    = 16'(int'($urandom_range(768, 0)) - 256);
                settings[REG_KI]    = 16'(int'($urandom_range(320, 0)) - 64);
                settings[REG_KD]    = 16'(int'($urandom_range(48, 0)) - 24);
                settings[REG_DT]    = 16'($urandom_range(65535, 0));
                settings[REG_INV]   = 16'($urandom_range(2047, 0));
                settings[REG_TGT]   = 16'($urandom());
                settings[REG_LIMIT] = 16'($urandom_range(32767, 0));
            end
        endcase
    endtask

    // mostly a slow walk around the target, with noise and extremes mixed in
    function automatic logic signed [POSITION_BITS-1:0] next_sample();
        int pick;
        pick = int'($urandom_range(99, 0));
        if (pick < 70)
        begin
            walk = walk + int'($urandom_range(600, 0)) - 300;
            if (walk > 32767)
            begin
                walk = 32767;
            end
            if (walk < -32768)
            begin
                walk = -32768;
            end
            return POSITION_BITS'(walk);
        end
        if (pick < 85)
        begin
            return POSITION_BITS'($urandom());
        end
        case ($urandom_range(4, 0))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return settings[REG_TGT];
        endcase
    endfunction

    initial
    begin
        sensor_ch.valid     = 1'b0;
        sensor_ch.joint_pos = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        result_ch.ready     = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset defaults
        send_sample(16'sh0000);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sd6434);
        send_sample(16'shffff);
        send_sample(16'sd12868);
        drain();

        // largest gains and periods: drive the integral and derivative terms into saturation
        pick_settings(SET_TOP);
        load_settings();
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sh0000);
        send_sample(16'sh0000);
        drain();

        // ignored index, then zero timestep and zero inverse timestep
        write_reg(SPARE_REG_INDEX, 16'hffff);
        write_reg(REG_DT, 16'h0000);
        write_reg(REG_INV, 16'h0000);
        cfg_ch.valid = 1'b0;
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh1234);
        drain();

        // most negative gains, zero limit: every command comes out zero
        pick_settings(SET_BOTTOM);
        load_settings();
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sh0000);
        send_sample(16'shffff);
        drain();

        for (round = 0; round < ROUNDS; round++)
        begin
            case (round % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 47;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 47;
                end
                default:
                begin
                    sender_idle_pct    = 8;
                    receiver_stall_pct = 8;
                end
            endcase
            case (round)
                1:       pick_settings(SET_TOP);
                3:       pick_settings(SET_BOTTOM);
                6:       pick_settings(SET_FULL);
                default: pick_settings(SET_MODERATE);
            endcase
            load_settings();
            walk = int'($signed(settings[REG_TGT])) + int'($urandom_range(4000, 0)) - 2000;
            for (n = 0; n < SAMPLES_PER_ROUND; n++)
            begin
                send_sample(next_sample());
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("summary: %0d command words checked under %0d register settings",
                 checked, settings_count);
        $display("summary: gain, period and limit extremes; no idling, sender, receiver, both");
        if (failures == 0 && pending == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: pid_position_controller.f
+incdir+design
design/pidpc_pkg.sv
design/pidpc_if.sv
design/pidpc_regs.sv
design/pidpc_seq.sv
design/pidpc_dp.sv
design/pid_position_controller.sv
test/pid_position_controller_checker.sv
test/pid_position_controller_tb.sv
